/* rtl/core/tat_pkg.sv */
// Shared constants and types for the token aging table.
// Used by every module in rtl/core; depends on nothing else.
package tat_pkg;

  localparam int TOKEN_COUNT = 256;
  localparam int IDX_W       = $clog2(TOKEN_COUNT);
  localparam int TOKEN_W     = 8;
  localparam int TIME_W      = 32;
  localparam int COUNT_W     = 9;
  localparam int CMD_W       = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TIME_W-1:0]  TTL_RESET = TIME_W'(100);

  localparam logic [CMD_W-1:0] CMD_GENERATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RENEW    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COUNT    = 2'd2;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic clear;
    logic sample;
    logic present;
  } cnt_ctl_t;

endpackage

/* rtl/core/tat_stamp_ram.sv */
// Stamp memory: one write port, one read port, registered read data.
// Depends on tat_pkg.
module tat_stamp_ram
  import tat_pkg::*;
(
  input  logic  clk,
  input  logic  we,
  input  idx_t  waddr,
  input  time_t wdata,
  input  idx_t  raddr,
  output time_t rdata
);

  time_t mem [TOKEN_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/tat_live_counter.sv */
// Checks one table entry per cycle against the time-to-live and counts the live ones.
// Depends on tat_pkg.
module tat_live_counter
  import tat_pkg::*;
(
  input  logic     clk,
  input  cnt_ctl_t ctl,
  input  time_t    stamp,
  input  time_t    now,
  input  time_t    ttl,
  output count_t   count
);

  time_t elapsed;
  logic  live;

  assign elapsed = now - stamp;
  assign live    = ctl.present && ((now < stamp) || (elapsed < ttl));

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      count <= '0;
    end else if (ctl.sample && live && (count != COUNT_MAX)) begin
      count <= count + COUNT_W'(1);
    end
  end

endmodule

/* rtl/core/token_aging_table.sv */
// Token aging table: generate and renew give no result.
// A count walks all TOKEN_COUNT entries, one memory read per cycle; the sweep is
// followed by a drain state, and the result is registered into live_count in the done
// state, which waits while an earlier stalled result is still held; the input stalls
// until then. Reset sets the time-to-live to 100 and starts a pass over all TOKEN_COUNT
// entries that clears the present flags; the input stalls until the pass has ended.
module token_aging_table
  import tat_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   command,
  input  logic [TOKEN_W-1:0] token_index,
  input  logic [TIME_W-1:0]  now_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COUNT_W-1:0] live_count,
  input  logic               cfg_write,
  input  logic [TIME_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    SWEEP,
    DRAIN,
    DONE
  } state_t;

  state_t   state;
  time_t    ttl;
  time_t    now_reg;
  idx_t     sweep_idx;
  logic     rd_valid;
  logic     rd_present;
  logic     present [TOKEN_COUNT];
  logic     accept;
  logic     in_range;
  idx_t     idx;
  logic     we;
  logic     start;
  logic     clearing;
  logic     pres_we;
  idx_t     pres_addr;
  logic     pres_wdata;
  time_t    rdata;
  count_t   count;
  cnt_ctl_t ctl;

  assign in_stall = (state != IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_range = (int'(token_index) < TOKEN_COUNT);
  assign idx      = IDX_W'(token_index);
  assign start    = accept && (command == CMD_COUNT);

  // A renew of a token that was never generated writes a stamp that never takes part in a count,
  // because only a generate sets the present flag and it writes the stamp as well.
  assign we       = accept && in_range &&
                    ((command == CMD_GENERATE) || (command == CMD_RENEW));

  assign clearing   = (state == CLEAR);
  assign pres_we    = clearing || (accept && in_range && (command == CMD_GENERATE));
  assign pres_addr  = clearing ? sweep_idx : idx;
  assign pres_wdata = !clearing;

  assign ctl.clear   = start;
  assign ctl.sample  = rd_valid;
  assign ctl.present = rd_present;

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl <= TTL_RESET;
    end else if (cfg_write) begin
      ttl <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pres_we) begin
      present[pres_addr] <= pres_wdata;
    end
    rd_present <= present[sweep_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CLEAR;
      sweep_idx  <= '0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_valid   <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        CLEAR: begin
          if (sweep_idx == IDX_W'(TOKEN_COUNT - 1)) begin
            sweep_idx <= '0;
            state     <= IDLE;
          end else begin
            sweep_idx <= sweep_idx + IDX_W'(1);
          end
        end
        IDLE: begin
          if (start) begin
            now_reg   <= now_time;
            sweep_idx <= '0;
            state     <= SWEEP;
          end
        end
        SWEEP: begin
          rd_valid <= 1'b1;
          if (sweep_idx == IDX_W'(TOKEN_COUNT - 1)) begin
            state <= DRAIN;
          end else begin
            sweep_idx <= sweep_idx + IDX_W'(1);
          end
        end
        DRAIN: begin
          state <= DONE;
        end
        DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            live_count <= count;
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  tat_stamp_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx),
    .wdata (now_time),
    .raddr (sweep_idx),
    .rdata (rdata)
  );

  tat_live_counter u_counter (
    .clk   (clk),
    .ctl   (ctl),
    .stamp (rdata),
    .now   (now_reg),
    .ttl   (ttl),
    .count (count)
  );

endmodule
